// ===== hdl/rgsg_pkg.sv =====
// rgsg_pkg: shared constants, types and the sequencer program of the rake grid seed generator
// depends on nothing; used by the divider lane and the top level
package rgsg_pkg;

    // default widths
    localparam int COUNT_BITS_DEF = 8;
    localparam int COORD_BITS_DEF = 32;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LO_X   = 3'd0,
        REG_LO_Y   = 3'd1,
        REG_LO_Z   = 3'd2,
        REG_HI_X   = 3'd3,
        REG_HI_Y   = 3'd4,
        REG_HI_Z   = 3'd5,
        REG_COUNTS = 3'd6
    } t_cfg_reg;

    // seeding mode, from the number of axes that are not flat
    typedef enum logic [1:0] {
        MODE_POINT = 2'd0,
        MODE_LINE  = 2'd1,
        MODE_PLANE = 2'd2,
        MODE_SOLID = 2'd3
    } t_mode;

    // micro-operations of the sequencer datapath
    typedef enum logic [2:0] {
        OP_WAIT   = 3'd0,
        OP_MUL_XY = 3'd1,
        OP_MUL_Z  = 3'd2,
        OP_LOAD   = 3'd3,
        OP_ITER   = 3'd4,
        OP_EMIT   = 3'd5,
        OP_NONE   = 3'd6
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEXT      = 3'd0,
        C_ALWAYS    = 3'd1,
        C_NO_IN     = 3'd2,
        C_BAD       = 3'd3,
        C_ITER_MORE = 3'd4,
        C_OUT_BUSY  = 3'd5
    } t_cond;

    typedef logic [2:0] t_upc;

    localparam t_upc STEP_IDLE   = 3'd0;
    localparam t_upc STEP_MUL_XY = 3'd1;
    localparam t_upc STEP_MUL_Z  = 3'd2;
    localparam t_upc STEP_LOAD   = 3'd3;
    localparam t_upc STEP_ITER   = 3'd4;
    localparam t_upc STEP_EMIT   = 3'd5;
    localparam t_upc STEP_RET    = 3'd6;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_uword;

    // control program: a jump is taken when the condition holds, else the next step follows
    function automatic t_uword prog_rom(input t_upc pc);
        t_uword w;
        unique case (pc)
            STEP_IDLE:   w = '{op: OP_WAIT,   cond: C_NO_IN,     target: STEP_IDLE};
            STEP_MUL_XY: w = '{op: OP_MUL_XY, cond: C_NEXT,      target: STEP_IDLE};
            STEP_MUL_Z:  w = '{op: OP_MUL_Z,  cond: C_NEXT,      target: STEP_IDLE};
            STEP_LOAD:   w = '{op: OP_LOAD,   cond: C_BAD,       target: STEP_EMIT};
            STEP_ITER:   w = '{op: OP_ITER,   cond: C_ITER_MORE, target: STEP_ITER};
            STEP_EMIT:   w = '{op: OP_EMIT,   cond: C_OUT_BUSY,  target: STEP_EMIT};
            STEP_RET:    w = '{op: OP_NONE,   cond: C_ALWAYS,    target: STEP_IDLE};
            default:     w = '{op: OP_NONE,   cond: C_ALWAYS,    target: STEP_IDLE};
        endcase
        return w;
    endfunction

    // control from the sequencer to each divider lane
    typedef struct packed {
        logic load;
        logic step;
    } t_lane_ctrl;

endpackage

// ===== hdl/rgsg_if.sv =====
// rgsg_if: valid/ready channels of the rake grid seed generator, command in and point out
// depends on nothing
interface rgsg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface rgsg_out_if #(
    parameter int COORD_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic                         last_point;
    logic                         no_point;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    output last_point, output no_point, input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    input last_point, input no_point, output ready);
endinterface

// ===== hdl/rake_grid_seed_generator.sv =====
// rake_grid_seed_generator: top level, config registers, microcoded sequencer, walk state
// depends on rgsg_pkg, rgsg_if (rgsg_in_if, rgsg_out_if) and rgsg_lane
//
// Emits evenly spaced seed points inside an axis-aligned box given by two signed
// Q16.16 corners (extent origin already added). Each command item gives one point
// item: restart=1 returns the first point of the grid, restart=0 the next one.
// The mode follows from how many axes are flat: three flat axes repeat the box
// midpoint, two flat axes step along the diagonal at (t+1)/(T+1) with T=nx*ny*nz,
// one or none walk x fastest, then y, then z, at (i+1)/(n+1) on each axis. A zero
// count, or plane mode with no count equal to one, gives a point item with no_point
// set and zero coordinates. After the last point the walk starts over.
// Steps: an item passes idle, the x*y multiply, the z multiply, load, the divider
// iterations, emit and return; the iterations drive the three radix-2 multiply-divide
// lanes, which consume one magnitude bit per cycle. An empty or invalid grid skips the
// lanes and goes from load straight to emit. A finished point waits in the output
// register while the next command is already being worked on; the sequencer only
// holds in its emit step while that register is occupied and its point is not taken.
// Configuration writes are taken on any cycle and must only be made while idle.
module rake_grid_seed_generator import rgsg_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rgsg_in_if.sink               i_cmd,
    rgsg_out_if.source            o_pnt,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [(COORD_BITS > 3 * COUNT_BITS ? COORD_BITS : 3 * COUNT_BITS)-1:0] i_cfg_data
);

    localparam int LIN_W = 3 * COUNT_BITS;      // linear index and grid total
    localparam int DEN_W = LIN_W + 1;           // denominators up to total+1
    localparam int XY_W  = 2 * COUNT_BITS;
    localparam int IT_W  = $clog2(COORD_BITS);

    // ---------------------------------------------------------------- config registers
    logic [COORD_BITS-1:0] r_lo [3];
    logic [COORD_BITS-1:0] r_hi [3];
    logic [LIN_W-1:0]      r_counts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= '0;
                r_hi[a] <= '0;
            end
            r_counts <= {3{COUNT_BITS'(1)}};
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_LO_X:   r_lo[0]  <= i_cfg_data[COORD_BITS-1:0];
                REG_LO_Y:   r_lo[1]  <= i_cfg_data[COORD_BITS-1:0];
                REG_LO_Z:   r_lo[2]  <= i_cfg_data[COORD_BITS-1:0];
                REG_HI_X:   r_hi[0]  <= i_cfg_data[COORD_BITS-1:0];
                REG_HI_Y:   r_hi[1]  <= i_cfg_data[COORD_BITS-1:0];
                REG_HI_Z:   r_hi[2]  <= i_cfg_data[COORD_BITS-1:0];
                REG_COUNTS: r_counts <= i_cfg_data[LIN_W-1:0];
                default:    ;   // index beyond the register list is dropped
            endcase
        end
    end

    // ---------------------------------------------------------------- grid shape
    logic [COUNT_BITS-1:0] cnt [3];
    logic [2:0]            flat;
    logic [1:0]            dims;
    t_mode                 mode;
    logic                  any_zero;
    logic                  any_one;
    logic                  bad;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            cnt[a]  = r_counts[a*COUNT_BITS +: COUNT_BITS];
            flat[a] = (r_lo[a] == r_hi[a]);
        end
        dims     = {1'b0, !flat[0]} + {1'b0, !flat[1]} + {1'b0, !flat[2]};
        mode     = t_mode'(dims);
        any_zero = (cnt[0] == '0) || (cnt[1] == '0) || (cnt[2] == '0);
        any_one  = (cnt[0] == COUNT_BITS'(1)) || (cnt[1] == COUNT_BITS'(1)) ||
                   (cnt[2] == COUNT_BITS'(1));
        bad      = any_zero || ((mode == MODE_PLANE) && !any_one);
    end

    // ---------------------------------------------------------------- sequencer
    t_upc   r_upc;
    t_upc   n_upc;
    t_uword uw;
    logic   take;
    logic   in_fire;
    logic   out_busy;
    logic   emit_fire;
    logic   r_out_valid;
    logic [IT_W-1:0] r_iter;

    assign uw          = prog_rom(r_upc);
    assign i_cmd.ready = (uw.op == OP_WAIT);
    assign in_fire     = i_cmd.valid && i_cmd.ready;
    assign out_busy    = r_out_valid && !o_pnt.ready;
    assign emit_fire   = (uw.op == OP_EMIT) && !out_busy;

    always_comb begin
        case (uw.cond)
            C_NEXT:      take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_IN:     take = !in_fire;
            C_BAD:       take = bad;
            C_ITER_MORE: take = (r_iter != '0);
            C_OUT_BUSY:  take = out_busy;
            default:     take = 1'b1;
        endcase
        n_upc = take ? uw.target : t_upc'(r_upc + 3'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= STEP_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    // ---------------------------------------------------------------- grid total
    logic             r_restart;
    logic [XY_W-1:0]  r_prod_xy;
    logic [LIN_W-1:0] r_total;

    // one multiply per step, registered before the next
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_restart <= i_cmd.restart;
        end
        if (uw.op == OP_MUL_XY) begin
            r_prod_xy <= XY_W'(cnt[0]) * XY_W'(cnt[1]);
        end
        if (uw.op == OP_MUL_Z) begin
            r_total <= LIN_W'(r_prod_xy) * LIN_W'(cnt[2]);
        end
    end

    // ---------------------------------------------------------------- walk state
    logic [COUNT_BITS-1:0] r_idx [3];
    logic [LIN_W-1:0]      r_lin;
    logic                  r_done;
    logic                  r_bad;

    logic [COUNT_BITS-1:0] base_idx [3];
    logic [LIN_W-1:0]      base_lin;
    logic                  base_done;
    logic                  wrap;
    logic [COUNT_BITS-1:0] w_idx [3];
    logic [LIN_W-1:0]      w_lin;
    logic                  emit_last;

    logic [COUNT_BITS-1:0] n_idx [3];
    logic [LIN_W-1:0]      n_lin;
    logic                  n_done;
    logic [COUNT_BITS:0]   inc_x;
    logic [COUNT_BITS:0]   inc_y;

    always_comb begin
        // restart clears the walk, even for an invalid grid
        for (int a = 0; a < 3; a++) begin
            base_idx[a] = r_restart ? '0 : r_idx[a];
        end
        base_lin  = r_restart ? '0 : r_lin;
        base_done = r_restart ? 1'b0 : r_done;
        // start over after the last point or when the counts no longer cover the walk
        wrap = base_done || (base_idx[0] >= cnt[0]) || (base_idx[1] >= cnt[1]) ||
               (base_idx[2] >= cnt[2]) || (base_lin >= r_total);
        for (int a = 0; a < 3; a++) begin
            w_idx[a] = (wrap && !bad) ? '0 : base_idx[a];
        end
        w_lin = (wrap && !bad) ? '0 : base_lin;

        emit_last = (r_lin == r_total - LIN_W'(1));
        inc_x     = {1'b0, r_idx[0]} + (COUNT_BITS+1)'(1);
        inc_y     = {1'b0, r_idx[1]} + (COUNT_BITS+1)'(1);

        for (int a = 0; a < 3; a++) begin
            n_idx[a] = r_idx[a];
        end
        n_lin  = r_lin;
        n_done = r_done;
        if (uw.op == OP_LOAD) begin
            for (int a = 0; a < 3; a++) begin
                n_idx[a] = w_idx[a];
            end
            n_lin  = w_lin;
            n_done = (wrap && !bad) ? 1'b0 : base_done;
        end else if (emit_fire && !r_bad) begin
            if (emit_last) begin
                n_done = 1'b1;
            end else begin
                n_lin = r_lin + LIN_W'(1);
                // x fastest, then y, then z
                if (inc_x >= {1'b0, cnt[0]}) begin
                    n_idx[0] = '0;
                    if (inc_y >= {1'b0, cnt[1]}) begin
                        n_idx[1] = '0;
                        n_idx[2] = r_idx[2] + COUNT_BITS'(1);
                    end else begin
                        n_idx[1] = inc_y[COUNT_BITS-1:0];
                    end
                end else begin
                    n_idx[0] = inc_x[COUNT_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_idx[a] <= '0;
            end
            r_lin  <= '0;
            r_done <= 1'b0;
            r_bad  <= 1'b0;
            r_iter <= '0;
        end else begin
            for (int a = 0; a < 3; a++) begin
                r_idx[a] <= n_idx[a];
            end
            r_lin  <= n_lin;
            r_done <= n_done;
            if (uw.op == OP_LOAD) begin
                r_bad  <= bad;
                r_iter <= IT_W'(COORD_BITS - 1);
            end else if (uw.op == OP_ITER) begin
                r_iter <= r_iter - IT_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------- divider lanes
    t_lane_ctrl            lane_ctrl;
    logic [COORD_BITS:0]   diff [3];
    logic [COORD_BITS:0]   mag_full [3];
    logic [COORD_BITS-1:0] lane_mag [3];
    logic [DEN_W-1:0]      lane_num [3];
    logic [DEN_W-1:0]      lane_den [3];
    logic [COORD_BITS-1:0] lane_quot [3];
    logic [2:0]            r_neg;

    assign lane_ctrl.load = (uw.op == OP_LOAD);
    assign lane_ctrl.step = (uw.op == OP_ITER);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            diff[a]     = {r_hi[a][COORD_BITS-1], r_hi[a]} - {r_lo[a][COORD_BITS-1], r_lo[a]};
            mag_full[a] = diff[a][COORD_BITS] ? (~diff[a] + (COORD_BITS+1)'(1)) : diff[a];
            lane_mag[a] = mag_full[a][COORD_BITS-1:0];
            if (mode == MODE_LINE) begin
                // diagonal: (t+1)/(T+1), same fraction on every axis
                lane_num[a] = {1'b0, w_lin} + DEN_W'(1);
                lane_den[a] = {1'b0, r_total} + DEN_W'(1);
            end else begin
                lane_num[a] = DEN_W'(w_idx[a]) + DEN_W'(1);
                lane_den[a] = DEN_W'(cnt[a]) + DEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.op == OP_LOAD) begin
            for (int a = 0; a < 3; a++) begin
                r_neg[a] <= diff[a][COORD_BITS];
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        rgsg_lane #(
            .MAG_W (COORD_BITS),
            .DEN_W (DEN_W)
        ) u_lane (
            .i_clk  (i_clk),
            .i_ctrl (lane_ctrl),
            .i_mag  (lane_mag[g]),
            .i_num  (lane_num[g]),
            .i_den  (lane_den[g]),
            .o_quot (lane_quot[g])
        );
    end

    // ---------------------------------------------------------------- output register
    logic [COORD_BITS:0]   mid_sum [3];
    logic [COORD_BITS:0]   mid_adj [3];
    logic [COORD_BITS:0]   step_res [3];
    logic [COORD_BITS-1:0] coord [3];
    logic [COORD_BITS-1:0] r_coord [3];
    logic                  r_last;
    logic                  r_nop;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            // midpoint, halving truncated toward zero
            mid_sum[a]  = {r_lo[a][COORD_BITS-1], r_lo[a]} + {r_hi[a][COORD_BITS-1], r_hi[a]};
            mid_adj[a]  = mid_sum[a] + (COORD_BITS+1)'(mid_sum[a][COORD_BITS]);
            step_res[a] = r_neg[a] ?
                          {r_lo[a][COORD_BITS-1], r_lo[a]} - {1'b0, lane_quot[a]} :
                          {r_lo[a][COORD_BITS-1], r_lo[a]} + {1'b0, lane_quot[a]};
            if (r_bad) begin
                coord[a] = '0;
            end else if (mode == MODE_POINT) begin
                coord[a] = mid_adj[a][COORD_BITS:1];
            end else begin
                coord[a] = step_res[a][COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_pnt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            for (int a = 0; a < 3; a++) begin
                r_coord[a] <= coord[a];
            end
            r_last <= !r_bad && emit_last;
            r_nop  <= r_bad;
        end
    end

    assign o_pnt.valid      = r_out_valid;
    assign o_pnt.coord_x    = r_coord[0];
    assign o_pnt.coord_y    = r_coord[1];
    assign o_pnt.coord_z    = r_coord[2];
    assign o_pnt.last_point = r_last;
    assign o_pnt.no_point   = r_nop;

    // ---------------------------------------------------------------- assertions
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_upc == STEP_MUL_XY))
        else $error("accepted item did not start the total multiply");

    a_iter_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == OP_ITER && r_iter == '0) |=> (r_upc == STEP_EMIT))
        else $error("divider steps did not end in the emit step");

    a_nop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pnt.valid && o_pnt.no_point) |->
        (o_pnt.coord_x == '0 && o_pnt.coord_y == '0 && o_pnt.coord_z == '0 &&
         !o_pnt.last_point))
        else $error("empty grid item carries a point");

    a_done_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(emit_fire && !r_bad && emit_last))
        else $error("grid marked done without emitting its last point");

endmodule

// ===== hdl/rgsg_lane.sv =====
// rgsg_lane: one lane of floor(mag*num/den), one magnitude bit per step, radix-2
// depends on rgsg_pkg (t_lane_ctrl and the default widths)
module rgsg_lane import rgsg_pkg::*; #(
    parameter int MAG_W = COORD_BITS_DEF,
    parameter int DEN_W = 3 * COUNT_BITS_DEF + 1
) (
    input  logic             i_clk,
    input  t_lane_ctrl       i_ctrl,
    input  logic [MAG_W-1:0] i_mag,
    input  logic [DEN_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [MAG_W-1:0] o_quot
);

    localparam int ACC_W = DEN_W + 2;

    logic [MAG_W-1:0] r_mag;
    logic [MAG_W-1:0] r_quot;
    logic [DEN_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;

    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] den1;
    logic [ACC_W-1:0] den2;
    logic [ACC_W-1:0] n_rem;
    logic [1:0]       digit;

    // 2*rem + bit*num stays below 3*den, so the digit is 0, 1 or 2
    always_comb begin
        acc  = {1'b0, r_rem, 1'b0} + (r_mag[MAG_W-1] ? {2'b00, r_num} : '0);
        den1 = {2'b00, r_den};
        den2 = {1'b0, r_den, 1'b0};
        if (acc >= den2) begin
            digit = 2'd2;
            n_rem = acc - den2;
        end else if (acc >= den1) begin
            digit = 2'd1;
            n_rem = acc - den1;
        end else begin
            digit = 2'd0;
            n_rem = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_mag  <= i_mag;
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (i_ctrl.step) begin
            r_mag  <= {r_mag[MAG_W-2:0], 1'b0};
            r_rem  <= n_rem[DEN_W-1:0];
            r_quot <= {r_quot[MAG_W-2:0], 1'b0} + MAG_W'(digit);
        end
    end

    assign o_quot = r_quot;

endmodule
